FILE: rtl/bpa_pkg.sv
package bpa_pkg;

	// Default sizes
	localparam int MAX_WORDS_DEF  = 64;
	localparam int PAGE_BYTES_DEF = 4096;

	// Field widths
	localparam int OP_W     = 2;
	localparam int ADDR_W   = 24;
	localparam int FIRST_W  = 12;
	localparam int COUNT_W  = 13;
	localparam int STATUS_W = 2;
	localparam int WIU_W    = 7;

	// Page arithmetic: wide enough for first_page + page_count and for
	// address / PAGE_BYTES + 1, and for the page total at the largest bitmap
	localparam int CMP_W     = 20;
	localparam int WORD_BITS = 64;
	localparam logic [WORD_BITS-1:0] ALL_USED = '1;

	// Operations
	localparam logic [OP_W-1:0] OP_ALLOC         = 2'd0;
	localparam logic [OP_W-1:0] OP_FREE_PAGE     = 2'd1;
	localparam logic [OP_W-1:0] OP_FREE_RANGE    = 2'd2;
	localparam logic [OP_W-1:0] OP_RESERVE_RANGE = 2'd3;

	// Result status
	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_FREE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;

	// Register file
	localparam int PADDR_W = 3;
	localparam logic [PADDR_W-3:0] REG_WORDS_IN_USE = 1'b0;
	localparam logic [WIU_W-1:0] WIU_RESET = 7'd64;

endpackage

FILE: rtl/bpa_ram.sv
module bpa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/bitmap_page_allocator_core.sv
// First-fit page frame allocator over a bitmap of MAX_WORDS 64-bit words.
// Requests enter on req_valid/req_stall with operation, address, start_page
// and num_pages; one result per request leaves on resp_valid/resp_stall with
// status and page_address. words_in_use is written over the APB port.
// One request is in work at a time; the bitmap lives in a single-port-write,
// registered-read RAM and each word is read, modified and written back.
// Steps per request: a free page reads, modifies and writes back one word;
// an alloc makes one RAM read per word scanned, until a word with a free bit
// is found or the scan limit is reached; a range over n words is handled one
// word per cycle; an out-of-range or empty range goes straight to the result.
// The result register is loaded in S_DONE, after the last RAM access. A new request
// is taken while a result still waits; a stalled result holds its register,
// and the following request then waits in its final state until it frees.
// After reset the block sweeps all MAX_WORDS words to all-used, one word a
// cycle, and holds req_stall high during the sweep. Register
// writes are taken at any time; words_in_use resets to 64.
module bitmap_page_allocator_core #(
	parameter int MAX_WORDS  = bpa_pkg::MAX_WORDS_DEF,
	parameter int PAGE_BYTES = bpa_pkg::PAGE_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bpa_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [bpa_pkg::OP_W-1:0]      operation,
	input  logic [bpa_pkg::ADDR_W-1:0]    address,
	input  logic [bpa_pkg::FIRST_W-1:0]   start_page,
	input  logic [bpa_pkg::COUNT_W-1:0]   num_pages,
	output logic                          resp_valid,
	input  logic                          resp_stall,
	output logic [bpa_pkg::STATUS_W-1:0]  status,
	output logic [bpa_pkg::ADDR_W-1:0]    page_address
);

	import bpa_pkg::*;

	localparam int TOTAL_PAGES = MAX_WORDS * WORD_BITS;
	localparam int WA_W  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int WC_W  = $clog2(MAX_WORDS + 1);
	localparam int PG_W  = WA_W + 6;
	localparam int OFF_W = $clog2(PAGE_BYTES);

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_SCAN,
		S_RANGE,
		S_DONE
	} state_t;

	state_t               state_q;
	logic [WIU_W-1:0]     wiu_q;
	logic [WC_W-1:0]      rd_cnt_q;
	logic [WC_W-1:0]      scan_lim_q;
	logic                 iss_q;
	logic                 rd_v_s1;
	logic [WA_W-1:0]      rd_w_s1;
	logic                 rd_last_s1;
	logic [PG_W-1:0]      lo_q;
	logic [PG_W-1:0]      last_q;
	logic                 set_q;
	logic [STATUS_W-1:0]  res_status_q;
	logic [ADDR_W-1:0]    res_addr_q;
	logic                 resp_valid_q;
	logic [STATUS_W-1:0]  status_q;
	logic [ADDR_W-1:0]    page_addr_q;

	logic                 accept;
	logic                 cfg_wr;
	logic [CMP_W-1:0]     free_pg;
	logic [CMP_W-1:0]     rng_end;
	logic [CMP_W-1:0]     d_lo;
	logic [CMP_W-1:0]     d_end;
	logic [CMP_W-1:0]     d_last;
	logic                 d_bad;
	logic                 d_empty;
	logic [WC_W-1:0]      lim;
	logic [WA_W-1:0]      rd_addr;
	logic                 rd_last_now;
	logic [5:0]           hit_b;
	logic [PG_W-1:0]      hit_page;
	logic                 word_full;
	logic [WORD_BITS-1:0] m_lo;
	logic [WORD_BITS-1:0] m_hi;
	logic                 ram_we;
	logic [WA_W-1:0]      ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic [WORD_BITS-1:0] ram_rdata;

	function automatic logic [5:0] low_zero(input logic [WORD_BITS-1:0] w);
		logic [5:0] r;
		r = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!w[i]) begin
				r = 6'(i);
			end
		end
		return r;
	endfunction

	// Register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[PADDR_W-1:2] == REG_WORDS_IN_USE);
	assign prdata = (paddr[PADDR_W-1:2] == REG_WORDS_IN_USE) ? 32'(wiu_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wiu_q <= WIU_RESET;
		end else if (cfg_wr) begin
			wiu_q <= pwdata[WIU_W-1:0];
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;

	// Request decode
	always_comb begin
		free_pg = CMP_W'(address >> OFF_W);
		rng_end = CMP_W'(start_page) + CMP_W'(num_pages);
		if (operation == OP_FREE_PAGE) begin
			d_lo  = free_pg;
			d_end = free_pg + CMP_W'(1);
		end else begin
			d_lo  = CMP_W'(start_page);
			d_end = rng_end;
		end
		d_last  = d_end - CMP_W'(1);
		d_bad   = d_end > CMP_W'(TOTAL_PAGES);
		d_empty = (operation != OP_FREE_PAGE) && (num_pages == '0);
		lim     = (int'(wiu_q) > MAX_WORDS) ? WC_W'(MAX_WORDS) : WC_W'(wiu_q);
	end

	assign rd_addr     = rd_cnt_q[WA_W-1:0];
	assign rd_last_now = (state_q == S_SCAN) ? (rd_cnt_q == scan_lim_q - WC_W'(1))
		: (rd_addr == last_q[PG_W-1:6]);

	assign word_full = &ram_rdata;
	assign hit_b     = low_zero(ram_rdata);
	assign hit_page  = {rd_w_s1, hit_b};

	// Bits of the current word that fall inside the range
	assign m_lo = (rd_w_s1 == lo_q[PG_W-1:6]) ? (ALL_USED << lo_q[5:0]) : ALL_USED;
	assign m_hi = (rd_w_s1 == last_q[PG_W-1:6]) ? (ALL_USED >> (6'd63 - last_q[5:0]))
		: ALL_USED;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = rd_w_s1;
		ram_wdata = ram_rdata;
		case (state_q)
			S_INIT: begin
				ram_we    = 1'b1;
				ram_waddr = rd_addr;
				ram_wdata = ALL_USED;
			end
			S_SCAN: begin
				ram_we    = rd_v_s1 && !word_full;
				ram_wdata = ram_rdata | (WORD_BITS'(1) << hit_b);
			end
			S_RANGE: begin
				ram_we    = rd_v_s1;
				ram_wdata = set_q ? (ram_rdata | (m_lo & m_hi))
					: (ram_rdata & ~(m_lo & m_hi));
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	bpa_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (MAX_WORDS),
		.AW    (WA_W)
	) u_bitmap (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (iss_q),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			rd_cnt_q     <= '0;
			scan_lim_q   <= '0;
			iss_q        <= 1'b0;
			rd_v_s1      <= 1'b0;
			rd_w_s1      <= '0;
			rd_last_s1   <= 1'b0;
			lo_q         <= '0;
			last_q       <= '0;
			set_q        <= 1'b0;
			res_status_q <= ST_OK;
			res_addr_q   <= '0;
			resp_valid_q <= 1'b0;
			status_q     <= ST_OK;
			page_addr_q  <= '0;
		end else begin
			rd_v_s1    <= iss_q;
			rd_w_s1    <= rd_addr;
			rd_last_s1 <= rd_last_now;
			if (iss_q) begin
				rd_cnt_q <= rd_cnt_q + WC_W'(1);
				if (rd_last_now) begin
					iss_q <= 1'b0;
				end
			end
			if (resp_valid_q && !resp_stall) begin
				resp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_INIT: begin
					rd_cnt_q <= rd_cnt_q + WC_W'(1);
					if (rd_cnt_q == WC_W'(MAX_WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						res_addr_q <= '0;
						unique case (operation) inside
							OP_ALLOC: begin
								scan_lim_q <= lim;
								if (lim == '0) begin
									res_status_q <= ST_NO_FREE;
									state_q      <= S_DONE;
								end else begin
									rd_cnt_q <= '0;
									iss_q    <= 1'b1;
									state_q  <= S_SCAN;
								end
							end
							OP_FREE_PAGE, OP_FREE_RANGE, OP_RESERVE_RANGE: begin
								lo_q   <= PG_W'(d_lo);
								last_q <= PG_W'(d_last);
								set_q  <= (operation == OP_RESERVE_RANGE);
								if (d_bad) begin
									res_status_q <= ST_RANGE;
									state_q      <= S_DONE;
								end else if (d_empty) begin
									res_status_q <= ST_OK;
									state_q      <= S_DONE;
								end else begin
									res_status_q <= ST_OK;
									rd_cnt_q     <= WC_W'(d_lo[PG_W-1:6]);
									iss_q        <= 1'b1;
									state_q      <= S_RANGE;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (rd_v_s1) begin
						if (!word_full) begin
							// drop the read still in flight
							iss_q        <= 1'b0;
							res_status_q <= ST_OK;
							res_addr_q   <= ADDR_W'({hit_page, {OFF_W{1'b0}}});
							state_q      <= S_DONE;
						end else if (rd_last_s1) begin
							res_status_q <= ST_NO_FREE;
							state_q      <= S_DONE;
						end
					end
				end
				S_RANGE: begin
					if (rd_v_s1 && rd_last_s1) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					// hold until the result register is free
					if (!resp_valid_q || !resp_stall) begin
						resp_valid_q <= 1'b1;
						status_q     <= res_status_q;
						page_addr_q  <= res_addr_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_INIT;
				end
			endcase
		end
	end

	assign resp_valid   = resp_valid_q;
	assign status       = status_q;
	assign page_address = page_addr_q;

endmodule
